FILE: design/clcg_pkg.sv
// shared types and constants of the combined lcg draw block
package clcg_pkg;

  localparam int GenW  = 31;
  localparam int ProdW = 2 * GenW;
  localparam int FoldW = 8;

  // moduli are 2^31 minus a small fold constant
  localparam logic [GenW-1:0]  MOD_ONE  = 31'd2147483563;
  localparam logic [GenW-1:0]  MOD_TWO  = 31'd2147483399;
  localparam logic [FoldW-1:0] FOLD_ONE = 8'd85;
  localparam logic [FoldW-1:0] FOLD_TWO = 8'd249;

  // offset added when the difference drops below one
  localparam logic [GenW-1:0]  WRAP_ADD = 31'd2147483562;

  localparam logic [GenW-1:0]  RST_MULT_ONE = 31'd40014;
  localparam logic [GenW-1:0]  RST_MULT_TWO = 31'd40692;
  localparam logic [GenW-1:0]  RST_START    = 31'd1;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_MULT_ONE  = 2'd0,
    REG_MULT_TWO  = 2'd1,
    REG_START_ONE = 2'd2,
    REG_START_TWO = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [GenW-1:0] mult_one;
    logic [GenW-1:0] mult_two;
    logic [GenW-1:0] start_one;
    logic [GenW-1:0] start_two;
  } cfg_t;

endpackage

FILE: design/combined_lcg_leapfrog_draw.sv
// top level of the combined two-component multiplicative lcg draw block
//
//  channel | ports                              | direction
//  --------+------------------------------------+----------
//  input   | in_valid, in_stall, in_reseed      | in, but in_stall out
//  result  | out_valid, out_stall, out_rand_value | out, but out_stall in
//  config  | cfg_wr_en, cfg_index, cfg_wdata    | in
//
// one beat in per cycle unless in_stall is high; its result appears in the output register on the next cycle.
// the generator update (31x31 multiply and two constant folds) is combinational.
// reset loads the multipliers 40014 and 40692, start values 1 and generators 1.
// a held output stalls the input only while out_stall is high; no bubbles otherwise.
module combined_lcg_leapfrog_draw
  import clcg_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            in_reseed,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [GenW-1:0] out_rand_value,
  input  logic            cfg_wr_en,
  input  cfg_idx_t        cfg_index,
  input  logic [GenW-1:0] cfg_wdata
);

  cfg_t            cfg;
  logic            in_acc;
  logic [GenW-1:0] gen_one_r, gen_one_nxt;
  logic [GenW-1:0] gen_two_r, gen_two_nxt;
  logic [GenW-1:0] cur_one;
  logic [GenW-1:0] cur_two;
  logic [GenW-1:0] step_one;
  logic [GenW-1:0] step_two;
  logic [GenW-1:0] draw;
  logic            out_valid_r, out_valid_nxt;
  logic [GenW-1:0] out_rand_value_r;

  clcg_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // handshake: output register frees when taken
  assign in_stall = out_valid_r & out_stall;
  assign in_acc   = in_valid & ~in_stall;

  // reseed selects the start values for this draw
  assign cur_one = in_reseed ? cfg.start_one : gen_one_r;
  assign cur_two = in_reseed ? cfg.start_two : gen_two_r;

  clcg_combine u_combine (
    .val_one    (cur_one),
    .val_two    (cur_two),
    .rand_value (draw)
  );

  clcg_modmul u_step_one (
    .sel_two (1'b0),
    .mult    (cfg.mult_one),
    .val     (cur_one),
    .res     (step_one)
  );

  clcg_modmul u_step_two (
    .sel_two (1'b1),
    .mult    (cfg.mult_two),
    .val     (cur_two),
    .res     (step_two)
  );

  // generator advance on each accepted beat
  assign gen_one_nxt   = in_acc ? step_one : gen_one_r;
  assign gen_two_nxt   = in_acc ? step_two : gen_two_r;
  assign out_valid_nxt = in_acc | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_one_r   <= RST_START;
      gen_two_r   <= RST_START;
      out_valid_r <= 1'b0;
    end else begin
      gen_one_r   <= gen_one_nxt;
      gen_two_r   <= gen_two_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_rand_value_r <= draw;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_rand_value = out_rand_value_r;

  // an accepted beat always lands in the output register
  a_acc_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid)
    else $error("accepted beat did not reach the output register");

  // generators move only on an accepted beat
  a_gen_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |=> ($stable(gen_one_r) && $stable(gen_two_r)))
    else $error("generator state changed without an accepted beat");

  // an advance always leaves each generator below its modulus
  a_gen_range: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> ((gen_one_r < MOD_ONE) && (gen_two_r < MOD_TWO)))
    else $error("modular reduction left a generator out of range");

  // a stalled result is not overwritten
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(out_rand_value))
    else $error("held result changed under stall");

endmodule

FILE: design/clcg_cfg.sv
// configuration register bank of the combined lcg draw block
module clcg_cfg
  import clcg_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_wr_en,
  input  cfg_idx_t        cfg_index,
  input  logic [GenW-1:0] cfg_wdata,
  output cfg_t            cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_MULT_ONE:  cfg_nxt.mult_one  = cfg_wdata;
        REG_MULT_TWO:  cfg_nxt.mult_two  = cfg_wdata;
        REG_START_ONE: cfg_nxt.start_one = cfg_wdata;
        REG_START_TWO: cfg_nxt.start_two = cfg_wdata;
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mult_one  <= RST_MULT_ONE;
      cfg_r.mult_two  <= RST_MULT_TWO;
      cfg_r.start_one <= RST_START;
      cfg_r.start_two <= RST_START;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: design/clcg_modmul.sv
// multiply modulo 2^31 minus a small constant, by two folds and one subtract
module clcg_modmul
  import clcg_pkg::*;
(
  input  logic            sel_two,
  input  logic [GenW-1:0] mult,
  input  logic [GenW-1:0] val,
  output logic [GenW-1:0] res
);

  logic [FoldW-1:0]      fold_c;
  logic [GenW-1:0]       modulus;
  logic [ProdW-1:0]      prod;
  logic [GenW+FoldW:0]   sum1;
  logic [GenW+FoldW-1:0] hi_fold;
  logic [GenW+FoldW-1:0] mid_fold;
  logic [GenW:0]         sum2;
  logic [GenW:0]         sub2;

  // modulus choice, tied off at the instance
  assign fold_c  = sel_two ? FOLD_TWO : FOLD_ONE;
  assign modulus = sel_two ? MOD_TWO : MOD_ONE;

  assign prod = {{GenW{1'b0}}, mult} * {{GenW{1'b0}}, val};

  // first fold: high part times the constant back onto the low part
  assign hi_fold = {{FoldW{1'b0}}, prod[ProdW-1:GenW]} * {{GenW{1'b0}}, fold_c};
  assign sum1    = {1'b0, hi_fold} + {{(FoldW+1){1'b0}}, prod[GenW-1:0]};

  // second fold: at most nine high bits remain
  assign mid_fold = {{(GenW-1){1'b0}}, sum1[GenW+FoldW:GenW]}
                  * {{GenW{1'b0}}, fold_c};
  assign sum2     = mid_fold[GenW:0] + {1'b0, sum1[GenW-1:0]};

  // final correction, the sum stays below twice the modulus
  assign sub2 = sum2 - {1'b0, modulus};
  assign res  = (sum2 >= {1'b0, modulus}) ? sub2[GenW-1:0] : sum2[GenW-1:0];

endmodule

FILE: design/clcg_combine.sv
// difference of the two generators folded into the output range
module clcg_combine
  import clcg_pkg::*;
(
  input  logic [GenW-1:0] val_one,
  input  logic [GenW-1:0] val_two,
  output logic [GenW-1:0] rand_value
);

  logic signed [GenW+1:0] diff;
  logic signed [GenW+1:0] adj;

  assign diff = $signed({2'b00, val_one}) - $signed({2'b00, val_two});

  // below one: add the first modulus minus one
  assign adj = (diff < $signed({{(GenW+1){1'b0}}, 1'b1}))
             ? diff + $signed({2'b00, WRAP_ADD})
             : diff;

  assign rand_value = adj[GenW-1:0];

endmodule

FILE: test/draw_checker.sv
// checker for the combined lcg draw block: predicts every draw and compares results
module draw_checker
  import clcg_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_stall,
  input  logic            in_reseed,
  input  logic            out_valid,
  input  logic            out_stall,
  input  logic [GenW-1:0] out_rand_value,
  input  logic            cfg_wr_en,
  input  cfg_idx_t        cfg_index,
  input  logic [GenW-1:0] cfg_wdata,
  output int              mismatch_count,
  output int              draws_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned ModA = 64'd2147483563;
  localparam longint unsigned ModB = 64'd2147483399;

  // shadow registers and generator state
  logic [GenW-1:0] mul_a, mul_b, seed_a, seed_b;
  logic [GenW-1:0] state_a, state_b;
  logic [GenW-1:0] expected_draws[$];

  // one generator step: product reduced by its own modulus
  function automatic logic [GenW-1:0] step_gen(input logic [GenW-1:0] mul,
                                               input logic [GenW-1:0] cur,
                                               input longint unsigned modulus);
    longint unsigned prod;
    prod = 64'(mul) * 64'(cur);
    return GenW'(prod % modulus);
  endfunction

  // difference of the two generators, lifted by m1-1 when below one
  function automatic logic [GenW-1:0] combine_draw(input logic [GenW-1:0] ga,
                                                   input logic [GenW-1:0] gb);
    longint diff;
    diff = longint'(64'(ga)) - longint'(64'(gb));
    if (diff < 1) diff = diff + longint'(ModA) - 1;
    return diff[GenW-1:0];
  endfunction

  always @(posedge clk) begin : watch
    logic [GenW-1:0] want;
    if (!rst_n) begin
      mul_a          = 31'd40014;
      mul_b          = 31'd40692;
      seed_a         = 31'd1;
      seed_b         = 31'd1;
      state_a        = 31'd1;
      state_b        = 31'd1;
      mismatch_count = 0;
      expected_draws.delete();
    end else begin
      // result beat against the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_draws.size() == 0) begin
          $error("rand_value: beat with nothing expected, actual %0d", out_rand_value);
          mismatch_count++;
        end else begin
          want = expected_draws.pop_front();
          if (want !== out_rand_value) begin
            $error("rand_value: expected %0d, actual %0d", want, out_rand_value);
            mismatch_count++;
          end
        end
      end
      // input beat: optional reseed, draw, then advance both generators
      if (in_valid && !in_stall) begin
        if (in_reseed) begin
          state_a = seed_a;
          state_b = seed_b;
        end
        expected_draws.push_back(combine_draw(state_a, state_b));
        state_a = step_gen(mul_a, state_a, ModA);
        state_b = step_gen(mul_b, state_b, ModB);
      end
      // register writes
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_MULT_ONE:  mul_a  = cfg_wdata;
          REG_MULT_TWO:  mul_b  = cfg_wdata;
          REG_START_ONE: seed_a = cfg_wdata;
          REG_START_TWO: seed_b = cfg_wdata;
          default: ;
        endcase
      end
    end
    draws_pending = expected_draws.size();
  end

endmodule

FILE: test/tb.sv
// top of the combined lcg draw testbench: clock, reset, stimulus and verdict
module tb;
  import clcg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int              CycleLimit = 400000;
  localparam int              HoldCycles = 64;
  localparam int              SegBeats   = 112;
  localparam logic [GenW-1:0] TopOne     = 31'd2147483562;
  localparam logic [GenW-1:0] TopTwo     = 31'd2147483398;
  localparam logic [GenW-1:0] AllOnes    = 31'h7FFF_FFFF;

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_stall;
  logic            in_reseed;
  logic            out_valid;
  logic            out_stall;
  logic [GenW-1:0] out_rand_value;
  logic            cfg_wr_en;
  cfg_idx_t        cfg_index;
  logic [GenW-1:0] cfg_wdata;
  int              mismatch_count;
  int              draws_pending;

  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic hold_req      = 1'b0;
  logic hold_ack      = 1'b0;

  combined_lcg_leapfrog_draw u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_reseed      (in_reseed),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_rand_value (out_rand_value),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  draw_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_reseed      (in_reseed),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_rand_value (out_rand_value),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .draws_pending  (draws_pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("tb: errors");
    $finish;
  end

  // receiver: random stalls, or one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_ack) begin
        hold_ack  = hold_req;
        out_stall = 1'b1;
        repeat (HoldCycles - 1) @(negedge clk);
      end else begin
        out_stall = ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // one draw request beat, with random idle cycles ahead of it
  task automatic send_draw(input logic reseed);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid  = 1'b1;
    in_reseed = reseed;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // stop sending and wait until every draw has come back
  task automatic drain();
    in_valid = 1'b0;
    while (draws_pending != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [GenW-1:0] val);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // new register set, only once the block is idle
  task automatic load_regs(input logic [GenW-1:0] m1, input logic [GenW-1:0] m2,
                           input logic [GenW-1:0] s1, input logic [GenW-1:0] s2);
    drain();
    write_reg(REG_MULT_ONE, m1);
    write_reg(REG_MULT_TWO, m2);
    write_reg(REG_START_ONE, s1);
    write_reg(REG_START_TWO, s2);
  endtask

  // mostly in range, sometimes zero, one, the top, the modulus or all ones
  function automatic logic [GenW-1:0] pick_reg(input logic [GenW-1:0] top_val);
    case ($urandom_range(11))
      0:       return '0;
      1:       return 31'd1;
      2:       return top_val;
      3:       return top_val + 31'd1;
      4:       return AllOnes;
      default: return GenW'($urandom_range(top_val, 1));
    endcase
  endfunction

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_reseed = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = REG_MULT_ONE;
    cfg_wdata = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset state: equal generators give the wrapped top value
    send_draw(1'b0);
    send_draw(1'b0);
    send_draw(1'b1);
    send_draw(1'b0);

    // largest in-range multipliers, top first start and unit second start
    load_regs(TopOne, TopTwo, TopOne, 31'd1);
    send_draw(1'b1);
    send_draw(1'b0);
    send_draw(1'b0);

    // unit multipliers, negative difference
    load_regs(31'd1, 31'd1, 31'd1, TopTwo);
    send_draw(1'b1);
    send_draw(1'b0);

    // start equal to the modulus, out-of-range and zero multipliers
    load_regs(AllOnes, '0, TopOne + 31'd1, AllOnes);
    send_draw(1'b1);
    send_draw(1'b0);
    send_draw(1'b0);

    // zero start against an out-of-range start
    load_regs(31'd40014, 31'd40692, '0, AllOnes);
    send_draw(1'b1);
    send_draw(1'b0);

    // out-of-range start above a zero start
    load_regs(31'd40014, 31'd40692, AllOnes, '0);
    send_draw(1'b1);
    send_draw(1'b0);

    // random phases: receiver idle heavy, then sender idle heavy, then none
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 20;
          recv_idle_pct = 51;
        end
        1: begin
          send_idle_pct = 51;
          recv_idle_pct = 20;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < 4; seg++) begin
        load_regs(pick_reg(TopOne), pick_reg(TopTwo), pick_reg(TopOne), pick_reg(TopTwo));
        // long receiver hold-off while the sender keeps offering beats
        if (ph == 2 && seg == 1) hold_req = ~hold_req;
        send_draw(1'b1);
        for (int k = 1; k < SegBeats; k++) send_draw($urandom_range(9) == 0);
      end
    end

    drain();
    repeat (4) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

FILE: combined_lcg_leapfrog_draw.f
design/clcg_pkg.sv
design/clcg_cfg.sv
design/clcg_modmul.sv
design/clcg_combine.sv
design/combined_lcg_leapfrog_draw.sv
test/draw_checker.sv
test/tb.sv
